FILE: rtl/llrc_pkg.sv
// Package for the log line ring capture block: sizes, character codes,
// sequencer states and the byte filter. No dependencies.
package llrc_pkg;

    localparam int RING_LINES  = 256;
    localparam int LINE_BYTES  = 128;

    localparam int CHAR_W      = 7;
    localparam int SLOT_W      = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
    localparam int CNT_W       = $clog2(RING_LINES + 1);
    localparam int LEN_W       = $clog2(LINE_BYTES);
    localparam int STORE_DEPTH = RING_LINES * LINE_BYTES;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SUM_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int OFF_W       = (LEN_W > 7) ? LEN_W : 7;

    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_LOW   = 8'd32;
    localparam logic [7:0] CODE_HIGH  = 8'd126;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_CM_START,
        ST_CP_READ,
        ST_CP_WRITE,
        ST_CM_END,
        ST_APPEND,
        ST_FINISH
    } state_t;

    // Map a raw byte to its printable form: tab to space, anything else
    // outside the printable range to a dot.
    function automatic logic [CHAR_W-1:0] filter_byte(input logic [7:0] b);
        logic [CHAR_W-1:0] c;
        if (b == CODE_TAB)
        begin
            c = CHAR_SPACE;
        end
        else if (b < CODE_LOW || b > CODE_HIGH)
        begin
            c = CHAR_DOT;
        end
        else
        begin
            c = b[CHAR_W-1:0];
        end
        return c;
    endfunction

endpackage

FILE: rtl/llrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module llrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/log_line_ring_capture_top.sv
// Top level of the log line ring capture block: request sequencer, shared
// slot adder and address unit, and the three line memories.
// Depends on llrc_pkg and llrc_ram.
//
// Usage: the input channel (in_valid/in_ready) carries one request: a feed
// of one raw log byte (cmd 0) or a read of one stored character (cmd 1).
// The output channel (out_valid/out_ready) returns exactly one result per
// request: read_char, line_count, captured_total and committed.
// One request is worked at a time by a small sequencer around one modular
// slot adder and one line-store address unit. A commit copies the pending
// line, trimmed of trailing spaces, into the ring one character at a time
// through the pending-line memory read port, alternating a read step and a
// write step; a full line wraps, commits first and then appends the new byte.
// A new request is accepted only once the sequencer is back in idle, so
// requests are never overlapped.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already accepted and worked, and that request
// waits in its last step until the register frees up.
// Reset clears the line count, totals, ring pointers and pending line at
// once; no memory clearing pass is needed.
module log_line_ring_capture_top
    import llrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  byte_in,
    input  logic [7:0]  line_index,
    input  logic [6:0]  column,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  read_char,
    output logic [8:0]  line_count,
    output logic [31:0] captured_total,
    output logic        committed
);

    // control state
    state_t            state_reg,    state_next;
    logic [SLOT_W-1:0] oldest_reg,   oldest_next;
    logic [CNT_W-1:0]  stored_reg,   stored_next;
    logic [31:0]       captured_reg, captured_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic [LEN_W-1:0]  trim_len_reg, trim_len_next;
    logic              out_valid_reg, out_valid_next;

    // request and work payload
    logic              cmd_reg,      cmd_next;
    logic [7:0]        byte_reg,     byte_next;
    logic [CHAR_W-1:0] char_reg,     char_next;
    logic [7:0]        idx_reg,      idx_next;
    logic [6:0]        col_reg,      col_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [LEN_W-1:0]  copy_cnt_reg, copy_cnt_next;
    logic              append_reg,   append_next;
    logic              commit_reg,   commit_next;
    logic [CHAR_W-1:0] rc_reg,       rc_next;

    // result register
    logic [6:0]        read_char_reg, read_char_next;
    logic [8:0]        line_count_reg, line_count_next;
    logic [31:0]       total_reg,    total_next;
    logic              committed_reg, committed_next;

    // shared slot adder
    logic [SUM_W-1:0]  add_b;
    logic [SUM_W-1:0]  add_sum;
    logic [SLOT_W-1:0] add_slot;

    // line store address unit
    logic [OFF_W-1:0]    store_off;
    logic [STORE_AW-1:0] store_addr;

    // memory ports
    logic              len_we;
    logic [LEN_W-1:0]  len_rdata;
    logic              store_we;
    logic [CHAR_W-1:0] store_rdata;
    logic              pend_we;
    logic [CHAR_W-1:0] pend_rdata;

    logic [LEN_W-1:0]  cnt_inc;

    // oldest slot plus line index for a read, plus line count for a commit;
    // a full ring lands back on the oldest slot
    assign add_b    = (cmd_reg == CMD_READ) ? SUM_W'(idx_reg) : SUM_W'(stored_reg);
    assign add_sum  = SUM_W'(oldest_reg) + add_b;
    assign add_slot = (add_sum >= SUM_W'(RING_LINES))
                    ? SLOT_W'(add_sum - SUM_W'(RING_LINES))
                    : SLOT_W'(add_sum);

    assign store_off  = (state_reg == ST_CP_WRITE) ? OFF_W'(copy_cnt_reg) : OFF_W'(col_reg);
    assign store_addr = STORE_AW'(slot_reg) * STORE_AW'(LINE_BYTES) + STORE_AW'(store_off);

    assign cnt_inc = copy_cnt_reg + LEN_W'(1);

    assign len_we   = (state_reg == ST_CM_START);
    assign store_we = (state_reg == ST_CP_WRITE);
    assign pend_we  = (state_reg == ST_APPEND);

    llrc_ram #(
        .WIDTH (LEN_W),
        .DEPTH (RING_LINES)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (slot_reg),
        .wdata (trim_len_reg),
        .raddr (slot_reg),
        .rdata (len_rdata)
    );

    llrc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_addr),
        .wdata (pend_rdata),
        .raddr (store_addr),
        .rdata (store_rdata)
    );

    llrc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_BYTES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_len_reg),
        .wdata (char_reg),
        .raddr (copy_cnt_reg),
        .rdata (pend_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        stored_next     = stored_reg;
        captured_next   = captured_reg;
        pend_len_next   = pend_len_reg;
        trim_len_next   = trim_len_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        byte_next       = byte_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        col_next        = col_reg;
        slot_next       = slot_reg;
        copy_cnt_next   = copy_cnt_reg;
        append_next     = append_reg;
        commit_next     = commit_reg;
        rc_next         = rc_reg;
        read_char_next  = read_char_reg;
        line_count_next = line_count_reg;
        total_next      = total_reg;
        committed_next  = committed_reg;
        in_ready        = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    byte_next  = byte_in;
                    char_next  = filter_byte(byte_in);
                    idx_next   = line_index;
                    col_next   = column;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                slot_next   = add_slot;
                commit_next = 1'b0;
                rc_next     = '0;
                append_next = 1'b0;
                if (cmd_reg == CMD_READ)
                begin
                    if (SUM_W'(idx_reg) < SUM_W'(stored_reg))
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (byte_reg == CODE_LF)
                begin
                    state_next = ST_CM_START;
                end
                else if (byte_reg == CODE_CR)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    append_next = 1'b1;
                    // wrap: a full pending line commits before the new byte
                    if (pend_len_reg == LEN_W'(LINE_BYTES - 1))
                    begin
                        state_next = ST_CM_START;
                    end
                    else
                    begin
                        state_next = ST_APPEND;
                    end
                end
            end

            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                if (OFF_W'(col_reg) < OFF_W'(len_rdata))
                begin
                    rc_next = store_rdata;
                end
                state_next = ST_FINISH;
            end

            ST_CM_START:
            begin
                if (stored_reg >= CNT_W'(RING_LINES))
                begin
                    // evict the oldest line
                    if (oldest_reg == SLOT_W'(RING_LINES - 1))
                    begin
                        oldest_next = '0;
                    end
                    else
                    begin
                        oldest_next = oldest_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    stored_next = stored_reg + CNT_W'(1);
                end
                captured_next = captured_reg + 32'd1;
                commit_next   = 1'b1;
                copy_cnt_next = '0;
                if (trim_len_reg == '0)
                begin
                    state_next = ST_CM_END;
                end
                else
                begin
                    state_next = ST_CP_READ;
                end
            end

            ST_CP_READ:
            begin
                state_next = ST_CP_WRITE;
            end

            ST_CP_WRITE:
            begin
                copy_cnt_next = cnt_inc;
                if (cnt_inc == trim_len_reg)
                begin
                    state_next = ST_CM_END;
                end
                else
                begin
                    state_next = ST_CP_READ;
                end
            end

            ST_CM_END:
            begin
                pend_len_next = '0;
                trim_len_next = '0;
                if (append_reg)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_APPEND:
            begin
                pend_len_next = pend_len_reg + LEN_W'(1);
                // trailing spaces stay out of the trimmed length
                if (char_reg != CHAR_SPACE)
                begin
                    trim_len_next = pend_len_reg + LEN_W'(1);
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    read_char_next  = rc_reg;
                    line_count_next = 9'(stored_reg);
                    total_next      = captured_reg;
                    committed_next  = commit_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            stored_reg    <= '0;
            captured_reg  <= '0;
            pend_len_reg  <= '0;
            trim_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            stored_reg    <= stored_next;
            captured_reg  <= captured_next;
            pend_len_reg  <= pend_len_next;
            trim_len_reg  <= trim_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        byte_reg       <= byte_next;
        char_reg       <= char_next;
        idx_reg        <= idx_next;
        col_reg        <= col_next;
        slot_reg       <= slot_next;
        copy_cnt_reg   <= copy_cnt_next;
        append_reg     <= append_next;
        commit_reg     <= commit_next;
        rc_reg         <= rc_next;
        read_char_reg  <= read_char_next;
        line_count_reg <= line_count_next;
        total_reg      <= total_next;
        committed_reg  <= committed_next;
    end

    assign out_valid      = out_valid_reg;
    assign read_char      = read_char_reg;
    assign line_count     = line_count_reg;
    assign captured_total = total_reg;
    assign committed      = committed_reg;

endmodule
